@@ rtl/ptd_pkg.sv @@
package ptd_pkg;

	localparam int PAL_WORDS = 65536;
	localparam int PAL_AW = $clog2(PAL_WORDS);

	localparam logic [2:0] MODE_NONE  = 3'd0;
	localparam logic [2:0] MODE_A3I5  = 3'd1;
	localparam logic [2:0] MODE_I2    = 3'd2;
	localparam logic [2:0] MODE_I4    = 3'd3;
	localparam logic [2:0] MODE_I8    = 3'd4;
	localparam logic [2:0] MODE_BLOCK = 3'd5;
	localparam logic [2:0] MODE_A5I3  = 3'd6;
	localparam logic [2:0] MODE_D16   = 3'd7;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_C0T    = 2'd1;
	localparam logic [1:0] REG_BASE   = 2'd2;
	localparam logic [1:0] REG_FORMAT = 2'd3;

	localparam logic [1:0] BLK_THREE   = 2'd0;
	localparam logic [1:0] BLK_AVERAGE = 2'd1;
	localparam logic [1:0] BLK_FOUR    = 2'd2;
	localparam logic [1:0] BLK_BLEND   = 2'd3;

	typedef enum logic [2:0] {
		K_TEX,
		K_DIRECT,
		K_BLK01,
		K_BLK23,
		K_EMIT
	} kind_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic        c0t;
		logic [12:0] pbase;
		logic        fmt;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [PAL_AW-1:0] addr_a;
		logic [PAL_AW-1:0] addr_b;
		logic [14:0]       color;
		logic [7:0]        alpha;
		logic [1:0]        sel;
		logic [1:0]        bmode;
		logic              last;
	} op_t;

	function automatic logic [7:0] x5to8(input logic [4:0] c);
		return {c, c[4:2]};
	endfunction

endpackage

@@ rtl/ptd_issue.sv @@
module ptd_issue (
	input  logic           clk,
	input  logic           arst_n,
	input  ptd_pkg::cfg_t  cfg,
	input  logic           start,
	input  logic [31:0]    data,
	input  logic [15:0]    word,
	input  logic           adv,
	output logic           busy,
	output logic           last_op,
	output ptd_pkg::op_t   op
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [4:0]  ncnt_q;
	logic [31:0] data_q;
	logic [15:0] word_q;

	logic [7:0]  opaque;
	logic [7:0]  zalpha;
	logic [15:0] base16;
	logic [15:0] sum16;
	logic [7:0]  b;
	logic [7:0]  idx;

	assign busy = busy_q;
	assign last_op = (cnt_q == ncnt_q);

	always_comb begin
		opaque = cfg.fmt ? 8'd31 : 8'd255;
		zalpha = cfg.c0t ? 8'd0 : opaque;
		base16 = (cfg.mode == ptd_pkg::MODE_I2) ? {1'b0, cfg.pbase, 2'b00}
			: {cfg.pbase, 3'b000};
		b = data_q[7:0];
		idx = 8'd0;
		op.valid = busy_q;
		op.kind = ptd_pkg::K_TEX;
		op.alpha = opaque;
		op.color = data_q[14:0];
		op.sel = data_q[1:0];
		op.bmode = word_q[15:14];
		op.last = last_op;
		unique case (cfg.mode)
			ptd_pkg::MODE_A3I5: begin
				idx = {3'b000, b[4:0]};
				op.alpha = cfg.fmt ? {3'b000, b[7:5], b[7:6]} : {b[7:5], b[7:5], b[7:6]};
			end
			ptd_pkg::MODE_I2: begin
				idx = {6'd0, b[1:0]};
				op.alpha = (idx != 8'd0) ? opaque : zalpha;
			end
			ptd_pkg::MODE_I4: begin
				idx = {4'd0, b[3:0]};
				op.alpha = (idx != 8'd0) ? opaque : zalpha;
			end
			ptd_pkg::MODE_I8: begin
				idx = b;
				op.alpha = (idx != 8'd0) ? opaque : zalpha;
			end
			ptd_pkg::MODE_A5I3: begin
				idx = {5'd0, b[2:0]};
				op.alpha = cfg.fmt ? {3'b000, b[7:3]} : ptd_pkg::x5to8(b[7:3]);
			end
			ptd_pkg::MODE_D16: begin
				op.kind = ptd_pkg::K_DIRECT;
				op.alpha = data_q[15] ? opaque : 8'd0;
			end
			ptd_pkg::MODE_BLOCK: begin
				if (cnt_q == 5'd0) begin
					op.kind = ptd_pkg::K_BLK01;
				end else if (cnt_q == 5'd1) begin
					op.kind = ptd_pkg::K_BLK23;
				end else begin
					op.kind = ptd_pkg::K_EMIT;
				end
				op.alpha = (data_q[1:0] == 2'd3 && !word_q[15]) ? 8'd0 : opaque;
			end
			default: begin
				op.kind = ptd_pkg::K_TEX;
			end
		endcase
		if (cfg.mode == ptd_pkg::MODE_BLOCK) begin
			sum16 = base16 + {1'b0, word_q[13:0], 1'b0} + ((cnt_q == 5'd1) ? 16'd2 : 16'd0);
		end else begin
			sum16 = base16 + {8'd0, idx};
		end
		op.addr_a = sum16[ptd_pkg::PAL_AW-1:0];
		op.addr_b = sum16[ptd_pkg::PAL_AW-1:0] + ptd_pkg::PAL_AW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= 5'd0;
			ncnt_q <= 5'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 5'd0;
			unique case (cfg.mode)
				ptd_pkg::MODE_I2:    ncnt_q <= 5'd3;
				ptd_pkg::MODE_I4:    ncnt_q <= 5'd1;
				ptd_pkg::MODE_BLOCK: ncnt_q <= 5'd17;
				default:             ncnt_q <= 5'd0;
			endcase
		end else if (adv && busy_q) begin
			if (last_op) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			data_q <= data;
			word_q <= word;
		end else if (adv && busy_q) begin
			if (cfg.mode == ptd_pkg::MODE_I4) begin
				data_q <= {4'd0, data_q[31:4]};
			end else if (cfg.mode == ptd_pkg::MODE_I2
				|| (cfg.mode == ptd_pkg::MODE_BLOCK && cnt_q >= 5'd2)) begin
				data_q <= {2'd0, data_q[31:2]};
			end
		end
	end

endmodule

@@ rtl/paletted_texel_decoder_core.sv @@
// channel   direction  handshake             payload
// input     in         in_valid / in_ready   opcode pal_addr pal_data tex_data block_word
// texel     out        out_valid / out_ready red green blue alpha last
// config    in         APB write / read      texture_mode color0_transparent palette_base
//                                            out_format
// One texel leaves per cycle unless the texel side stalls or a block fetches palette entries:
// a3i5, i8, a5i3 and direct16 give one texel per transaction, i4 two, i2 four, a 4x4 block sixteen
// after two palette fetches on the two read ports; each passes the s1, s2 and output registers.
// Reset clears control and configuration; the palette memory holds no reset value.
// A stall on the texel side freezes the whole pipeline; nothing is dropped or repeated.
module paletted_texel_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [15:0] pal_addr,
	input  logic [14:0] pal_data,
	input  logic [31:0] tex_data,
	input  logic [15:0] block_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        last
);

	ptd_pkg::cfg_t cfg_q;
	ptd_pkg::op_t  op;
	logic busy;
	logic last_op;
	logic adv;
	logic in_acc;
	logic start;

	logic [14:0] mem [ptd_pkg::PAL_WORDS];

	logic          valid_s1;
	ptd_pkg::kind_t kind_s1;
	logic [14:0]   rda_s1;
	logic [14:0]   rdb_s1;
	logic [14:0]   color_s1;
	logic [7:0]    alpha_s1;
	logic [1:0]    sel_s1;
	logic [1:0]    bmode_s1;
	logic          last_s1;

	logic [14:0] cb0_q, cb1_q, cb2_q, cb3_q;

	logic       valid_s2;
	logic [7:0] r_s2, g_s2, b_s2, alpha_s2;
	logic       last_s2;

	logic [14:0] c15;
	logic [7:0]  r_n, g_n, b_n;
	logic        emit_n;

	function automatic logic [4:0] blend(input logic [7:0] p, input logic [7:0] q);
		logic [10:0] s;
		s = ({3'b000, p} << 2) + {3'b000, p} + ({3'b000, q} << 1) + {3'b000, q};
		return s[10:6];
	endfunction

	function automatic logic [7:0] blk_chan(input logic [1:0] sel, input logic [1:0] bm,
		input logic [4:0] p5, input logic [4:0] q5, input logic [4:0] c2, input logic [4:0] c3);
		logic [7:0] p;
		logic [7:0] q;
		logic [8:0] s;
		logic [7:0] res;
		p = ptd_pkg::x5to8(p5);
		q = ptd_pkg::x5to8(q5);
		s = {1'b0, p} + {1'b0, q};
		unique case (sel)
			2'd0: res = p;
			2'd1: res = q;
			2'd2: begin
				if (bm == ptd_pkg::BLK_AVERAGE) res = s[8:1];
				else if (bm == ptd_pkg::BLK_BLEND) res = ptd_pkg::x5to8(blend(p, q));
				else res = ptd_pkg::x5to8(c2);
			end
			default: begin
				if (bm == ptd_pkg::BLK_THREE || bm == ptd_pkg::BLK_AVERAGE) res = 8'hFF;
				else if (bm == ptd_pkg::BLK_BLEND) res = ptd_pkg::x5to8(blend(q, p));
				else res = ptd_pkg::x5to8(c3);
			end
		endcase
		return res;
	endfunction

	assign pready = 1'b1;
	assign adv = !out_valid || out_ready;
	assign in_ready = !busy || (adv && last_op);
	assign in_acc = in_valid && in_ready;
	assign start = in_acc && opcode && (cfg_q.mode != ptd_pkg::MODE_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				ptd_pkg::REG_MODE:   cfg_q.mode <= pwdata[2:0];
				ptd_pkg::REG_C0T:    cfg_q.c0t <= pwdata[0];
				ptd_pkg::REG_BASE:   cfg_q.pbase <= pwdata[12:0];
				ptd_pkg::REG_FORMAT: cfg_q.fmt <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			ptd_pkg::REG_MODE:   prdata = {29'd0, cfg_q.mode};
			ptd_pkg::REG_C0T:    prdata = {31'd0, cfg_q.c0t};
			ptd_pkg::REG_BASE:   prdata = {19'd0, cfg_q.pbase};
			ptd_pkg::REG_FORMAT: prdata = {31'd0, cfg_q.fmt};
		endcase
	end

	ptd_issue u_issue (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.start   (start),
		.data    (tex_data),
		.word    (block_word),
		.adv     (adv),
		.busy    (busy),
		.last_op (last_op),
		.op      (op)
	);

	always_ff @(posedge clk) begin
		if (in_acc && !opcode) begin
			mem[pal_addr[ptd_pkg::PAL_AW-1:0]] <= pal_data;
		end
		if (adv) begin
			rda_s1 <= mem[op.addr_a];
			rdb_s1 <= mem[op.addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			valid_s1 <= op.valid;
			valid_s2 <= valid_s1 && emit_n;
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= op.kind;
			color_s1 <= op.color;
			alpha_s1 <= op.alpha;
			sel_s1 <= op.sel;
			bmode_s1 <= op.bmode;
			last_s1 <= op.last;
			if (valid_s1 && kind_s1 == ptd_pkg::K_BLK01) begin
				cb0_q <= rda_s1;
				cb1_q <= rdb_s1;
			end
			if (valid_s1 && kind_s1 == ptd_pkg::K_BLK23) begin
				cb2_q <= rda_s1;
				cb3_q <= rdb_s1;
			end
			r_s2 <= r_n;
			g_s2 <= g_n;
			b_s2 <= b_n;
			alpha_s2 <= alpha_s1;
			last_s2 <= last_s1;
			red <= cfg_q.fmt ? {2'b00, r_s2[7:2]} : r_s2;
			green <= cfg_q.fmt ? {2'b00, g_s2[7:2]} : g_s2;
			blue <= cfg_q.fmt ? {2'b00, b_s2[7:2]} : b_s2;
			alpha <= alpha_s2;
			last <= last_s2;
		end
	end

	always_comb begin
		c15 = (kind_s1 == ptd_pkg::K_DIRECT) ? color_s1 : rda_s1;
		emit_n = !(kind_s1 == ptd_pkg::K_BLK01 || kind_s1 == ptd_pkg::K_BLK23);
		if (kind_s1 == ptd_pkg::K_EMIT) begin
			r_n = blk_chan(sel_s1, bmode_s1, cb0_q[4:0], cb1_q[4:0], cb2_q[4:0], cb3_q[4:0]);
			g_n = blk_chan(sel_s1, bmode_s1, cb0_q[9:5], cb1_q[9:5], cb2_q[9:5], cb3_q[9:5]);
			b_n = blk_chan(sel_s1, bmode_s1, cb0_q[14:10], cb1_q[14:10], cb2_q[14:10],
				cb3_q[14:10]);
		end else begin
			r_n = ptd_pkg::x5to8(c15[4:0]);
			g_n = ptd_pkg::x5to8(c15[9:5]);
			b_n = ptd_pkg::x5to8(c15[14:10]);
		end
	end

endmodule

@@ tb/paletted_texel_decoder_core_test.sv @@
module paletted_texel_decoder_core_test;

	typedef struct {
		bit        op;
		bit [15:0] pa;
		bit [14:0] pd;
		bit [31:0] td;
		bit [15:0] bw;
	} word_t;

	typedef struct {
		bit [7:0] r, g, b, a;
		bit       lst;
	} texel_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	logic pready;
	logic in_valid = 0, in_ready;
	logic opcode = 0;
	logic [15:0] pal_addr = 0;
	logic [14:0] pal_data = 0;
	logic [31:0] tex_data = 0;
	logic [15:0] block_word = 0;
	logic out_valid, out_ready = 0;
	logic [7:0] red, green, blue, alpha;
	logic last;

	paletted_texel_decoder_core DUT (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	word_t    pending[$];
	texel_t   texels_due[$];
	bit [14:0] palette[bit [15:0]];
	bit        written[bit [15:0]];
	bit [15:0] reads[$];
	word_t    cur;
	bit [2:0] tex_mode;
	bit       c0_clear;
	bit [12:0] pal_base;
	bit       fmt6665;
	bit       calm = 0;
	int       stall_req = 0, stall_seen = 0, hold_left = 0;
	int       mismatches = 0;

	function automatic bit [7:0] widen8(bit [4:0] c);
		return {c, c[4:2]};
	endfunction

	function automatic bit [15:0] base_of();
		return (tex_mode == ptd_pkg::MODE_I2) ? {1'b0, pal_base, 2'b0} : {pal_base, 3'b0};
	endfunction

	function automatic texel_t shade(bit [14:0] c, bit [7:0] a);
		texel_t t;
		if (fmt6665) begin
			t.r = {c[4:0], c[4]};
			t.g = {c[9:5], c[9]};
			t.b = {c[14:10], c[14]};
		end else begin
			t.r = widen8(c[4:0]);
			t.g = widen8(c[9:5]);
			t.b = widen8(c[14:10]);
		end
		t.a = a;
		t.lst = 0;
		return t;
	endfunction

	function automatic texel_t wide(bit [14:0] c, bit [7:0] a);
		texel_t t;
		t.r = widen8(c[4:0]);
		t.g = widen8(c[9:5]);
		t.b = widen8(c[14:10]);
		t.a = a;
		t.lst = 0;
		return t;
	endfunction

	function automatic bit [4:0] mix53(bit [7:0] p, bit [7:0] q);
		bit [11:0] s;
		s = p * 5 + q * 3;
		return s[10:6];
	endfunction

	function automatic bit [14:0] rd(bit [15:0] a);
		return palette.exists(a) ? palette[a] : 15'd0;
	endfunction

	function automatic void decode_word(word_t w);
		texel_t t, col[4];
		bit [7:0] opaque, zero_a, by;
		bit [15:0] bs, off;
		bit [3:0] ix;
		bit [2:0] a3;
		int n;
		n = texels_due.size();
		opaque = fmt6665 ? 8'd31 : 8'd255;
		zero_a = c0_clear ? 8'd0 : opaque;
		by = w.td[7:0];
		bs = base_of();
		if (!w.op) begin
			palette[w.pa] = w.pd;
			return;
		end
		case (tex_mode)
			ptd_pkg::MODE_A3I5: begin
				a3 = by[7:5];
				texels_due.push_back(shade(rd(bs + by[4:0]), fmt6665 ?
					{3'b0, a3, a3[2:1]} : {a3, a3, a3[2:1]}));
			end
			ptd_pkg::MODE_I2: for (int i = 0; i < 4; i++) begin
				ix = by[2*i +: 2];
				texels_due.push_back(shade(rd(bs + ix), ix != 0 ? opaque : zero_a));
			end
			ptd_pkg::MODE_I4: for (int i = 0; i < 2; i++) begin
				ix = by[4*i +: 4];
				texels_due.push_back(shade(rd(bs + ix), ix != 0 ? opaque : zero_a));
			end
			ptd_pkg::MODE_I8: texels_due.push_back(shade(rd(bs + by),
				by != 0 ? opaque : zero_a));
			ptd_pkg::MODE_A5I3: texels_due.push_back(shade(rd(bs + by[2:0]),
				fmt6665 ? {3'b0, by[7:3]} : widen8(by[7:3])));
			ptd_pkg::MODE_D16: texels_due.push_back(shade(w.td[14:0],
				w.td[15] ? opaque : 8'd0));
			ptd_pkg::MODE_BLOCK: begin
				off = bs + {w.bw[13:0], 1'b0};
				col[0] = wide(rd(off), 255);
				col[1] = wide(rd(off + 1), 255);
				case (w.bw[15:14])
					ptd_pkg::BLK_THREE: begin
						col[2] = wide(rd(off + 2), 255);
						col[3] = wide(15'h7FFF, 0);
					end
					ptd_pkg::BLK_AVERAGE: begin
						col[2].r = (9'(col[0].r) + col[1].r) >> 1;
						col[2].g = (9'(col[0].g) + col[1].g) >> 1;
						col[2].b = (9'(col[0].b) + col[1].b) >> 1;
						col[2].a = 255;
						col[3] = wide(15'h7FFF, 0);
					end
					ptd_pkg::BLK_FOUR: begin
						col[2] = wide(rd(off + 2), 255);
						col[3] = wide(rd(off + 3), 255);
					end
					default: begin
						col[2] = wide({mix53(col[0].b, col[1].b), mix53(col[0].g, col[1].g),
							mix53(col[0].r, col[1].r)}, 255);
						col[3] = wide({mix53(col[1].b, col[0].b), mix53(col[1].g, col[0].g),
							mix53(col[1].r, col[0].r)}, 255);
					end
				endcase
				for (int i = 0; i < 4; i++) begin
					col[i].lst = 0;
					if (fmt6665) begin
						col[i].r = col[i].r >> 2;
						col[i].g = col[i].g >> 2;
						col[i].b = col[i].b >> 2;
						col[i].a = col[i].a >> 3;
					end
				end
				for (int i = 0; i < 16; i++)
					texels_due.push_back(col[w.td[2*i +: 2]]);
			end
			default: ;
		endcase
		if (texels_due.size() > n) begin
			t = texels_due[$];
			t.lst = 1;
			texels_due[texels_due.size() - 1] = t;
		end
	endfunction

	function automatic void list_reads(bit [31:0] td, bit [15:0] bw);
		bit [15:0] bs, off;
		bs = base_of();
		reads.delete();
		case (tex_mode)
			ptd_pkg::MODE_A3I5: reads.push_back(bs + td[4:0]);
			ptd_pkg::MODE_I2: for (int i = 0; i < 4; i++) reads.push_back(bs + td[2*i +: 2]);
			ptd_pkg::MODE_I4: for (int i = 0; i < 2; i++) reads.push_back(bs + td[4*i +: 4]);
			ptd_pkg::MODE_I8: reads.push_back(bs + td[7:0]);
			ptd_pkg::MODE_A5I3: reads.push_back(bs + td[2:0]);
			ptd_pkg::MODE_BLOCK: begin
				off = bs + {bw[13:0], 1'b0};
				reads.push_back(off);
				reads.push_back(off + 1);
				if (bw[15:14] == ptd_pkg::BLK_THREE || bw[15:14] == ptd_pkg::BLK_FOUR)
					reads.push_back(off + 2);
				if (bw[15:14] == ptd_pkg::BLK_FOUR) reads.push_back(off + 3);
			end
			default: ;
		endcase
	endfunction

	function automatic void queue_write(bit [15:0] a, bit [14:0] d);
		word_t w;
		w.op = 0;
		w.pa = a;
		w.pd = d;
		w.td = $urandom;
		w.bw = $urandom;
		written[a] = 1;
		pending.push_back(w);
	endfunction

	function automatic void queue_decode(bit [31:0] td, bit [15:0] bw);
		word_t w;
		list_reads(td, bw);
		foreach (reads[i])
			if (!written.exists(reads[i])) queue_write(reads[i], $urandom);
		w.op = 1;
		w.pa = $urandom;
		w.pd = $urandom;
		w.td = td;
		w.bw = bw;
		pending.push_back(w);
	endfunction

	task automatic reg_write(bit [1:0] idx, bit [31:0] v);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic drain();
		wait (pending.size() == 0 && !in_valid && texels_due.size() == 0);
		repeat (6) @(posedge clk);
	endtask

	always @(posedge clk) begin
		bit took;
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			took = in_valid && in_ready;
			if (took) decode_word(cur);
			if (in_valid && !took) begin
			end else if (pending.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
				cur = pending.pop_front();
				opcode <= cur.op;
				pal_addr <= cur.pa;
				pal_data <= cur.pd;
				tex_data <= cur.td;
				block_word <= cur.bw;
				in_valid <= 1;
			end else begin
				in_valid <= 0;
			end
		end
	end

	always @(posedge clk) begin
		texel_t e;
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (texels_due.size() == 0) begin
					$display("%0t: texel with none due: %h %h %h %h %b", $time,
						red, green, blue, alpha, last);
					mismatches++;
				end else begin
					e = texels_due.pop_front();
					if ({red, green, blue, alpha, last} !== {e.r, e.g, e.b, e.a, e.lst}) begin
						$display("%0t: texel mismatch expected %h %h %h %h %b actual %h %h %h %h %b",
							$time, e.r, e.g, e.b, e.a, e.lst, red, green, blue, alpha, last);
						mismatches++;
					end
				end
			end
			if (stall_seen != stall_req) begin
				stall_seen = stall_req;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 0;
			end else begin
				out_ready <= calm || $urandom_range(99) >= 30;
			end
		end
	end

	initial begin
		#(12 * 1000000);
		$display("[paletted_texel_decoder_core] ERROR");
		$finish;
	end

	initial begin
		bit [31:0] td;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		queue_write(16'h0000, 15'h0000);
		queue_write(16'hFFFF, 15'h7FFF);
		for (int p = 0; p < 14; p++) begin
			drain();
			tex_mode = (p < 8) ? p[2:0] : $urandom_range(7, 1);
			c0_clear = (p < 4) ? p[0] : $urandom_range(1);
			pal_base = (p == 2 || p == 9) ? 13'h1FFF : (p == 5) ? 13'd0 : $urandom;
			fmt6665 = (p < 8) ? p[1] ^ p[2] : $urandom_range(1);
			calm = (p == 3);
			reg_write(ptd_pkg::REG_MODE, tex_mode);
			reg_write(ptd_pkg::REG_C0T, c0_clear);
			reg_write(ptd_pkg::REG_BASE, pal_base);
			reg_write(ptd_pkg::REG_FORMAT, fmt6665);
			if (p < 8) begin
				queue_decode(32'h0, 16'h0000);
				queue_decode(32'hFFFFFFFF, 16'hFFFF);
				queue_decode($urandom, {ptd_pkg::BLK_AVERAGE, 14'($urandom)});
				if (tex_mode == ptd_pkg::MODE_BLOCK) begin
					queue_decode(32'hE4E4E4E4, {ptd_pkg::BLK_FOUR, 14'($urandom)});
					queue_decode(32'h1B1B1B1B, {ptd_pkg::BLK_BLEND, 14'($urandom)});
				end
			end
			if (p == 5) stall_req++;
			for (int i = 0; i < 8; i++) begin
				if ($urandom_range(99) < 15) begin
					queue_write($urandom, $urandom);
				end else begin
					td = $urandom;
					if ($urandom_range(99) < 20) td[7:0] = 0;
					queue_decode(td, $urandom);
				end
			end
		end
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && texels_due.size() == 0)
			$display("[paletted_texel_decoder_core] OK");
		else
			$display("[paletted_texel_decoder_core] ERROR");
		$finish;
	end

endmodule
